/* rtl/core/grid_move_neighbor_generator_top_defines.svh */
// Assertion macros for the grid move neighbor generator.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef GRID_MOVE_NEIGHBOR_GENERATOR_TOP_DEFINES_SVH
`define GRID_MOVE_NEIGHBOR_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GMNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmng same-cycle check failed");
`define GMNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmng next-cycle check failed");
`else
`define GMNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GMNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/gmng_pkg.sv */
// Shared constants, types and helpers of the grid move neighbor generator.
// Used by every module of the block; depends on nothing.
package gmng_pkg;

    localparam int MAX_DIM    = 16;
    localparam int COORD_LIM  = 16;
    localparam int SIZE_LIMIT = (MAX_DIM < COORD_LIM) ? MAX_DIM : COORD_LIM;
    localparam int COORD_W    = 4;
    localparam int SIZE_W     = 5;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COST_W     = 8;
    localparam int AXIS_COST  = 100;
    localparam int DIAG_COST  = 141;
    localparam int NUM_AXIS   = 4;
    localparam int NUM_DIR    = 8;
    localparam int DIR_W      = 3;
    localparam int DCNT_W     = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 1'b1;

    localparam logic signed [1:0] STEP_DX [NUM_DIR] = '{
        2'sb01, 2'sb11, 2'sb00, 2'sb00, 2'sb01, 2'sb01, 2'sb11, 2'sb11
    };
    localparam logic signed [1:0] STEP_DY [NUM_DIR] = '{
        2'sb00, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb11, 2'sb01, 2'sb11
    };

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_TARGET = 2'd1,
        REQ_EXPAND = 2'd2,
        REQ_COVER  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               occupied;
        logic               planar;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic [COST_W-1:0]  move_cost;
        logic               target_moved;
        logic               found;
        logic               last;
    } t_move;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [ADDR_W-1:0] occ_addr(input logic [SIZE_W-1:0] x,
                                                   input logic [SIZE_W-1:0] y);
        return ADDR_W'(int'(x) * MAX_DIM + int'(y));
    endfunction

endpackage

/* rtl/core/gmng_occ_mem.sv */
// Occupancy store: one bit per cell, one write and one registered read port.
// Per-entry valid flops make unwritten cells read free. Depends on gmng_pkg.
module gmng_occ_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gmng_pkg::t_mem_req        i_req,
    output logic                      o_rd_data
);

    logic [gmng_pkg::DEPTH-1:0] r_vld;
    logic                       r_mem [gmng_pkg::DEPTH];
    logic                       r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_vld[i_req.raddr] & r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/gmng_step_unit.sv */
// Shared neighbor unit: offsets a source cell by one direction and checks bounds.
// Depends on gmng_pkg for the step tables and widths.
module gmng_step_unit (
    input  logic [gmng_pkg::COORD_W-1:0] i_src_x,
    input  logic [gmng_pkg::COORD_W-1:0] i_src_y,
    input  logic [gmng_pkg::DIR_W-1:0]   i_dir,
    input  logic [gmng_pkg::SIZE_W-1:0]  i_x_size,
    input  logic [gmng_pkg::SIZE_W-1:0]  i_y_size,
    output logic [gmng_pkg::SIZE_W-1:0]  o_nx,
    output logic [gmng_pkg::SIZE_W-1:0]  o_ny,
    output logic                         o_inb
);

    logic signed [1:0] dx;
    logic signed [1:0] dy;

    assign dx = gmng_pkg::STEP_DX[i_dir];
    assign dy = gmng_pkg::STEP_DY[i_dir];

    // a step below zero wraps high, so one unsigned compare covers both edges
    assign o_nx  = {1'b0, i_src_x} + {{(gmng_pkg::SIZE_W-2){dx[1]}}, dx};
    assign o_ny  = {1'b0, i_src_y} + {{(gmng_pkg::SIZE_W-2){dy[1]}}, dy};
    assign o_inb = (o_nx < i_x_size) && (o_ny < i_y_size);

endmodule

/* rtl/core/gmng_seq.sv */
// Request sequencer: grid writes, target register, per-direction expansion
// through the shared step unit, pending-move slot and output register.
// Depends on gmng_pkg, gmng_step_unit and the assertion macro header.
`include "grid_move_neighbor_generator_top_defines.svh"

module gmng_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gmng_pkg::SIZE_W-1:0] i_x_size,
    input  logic [gmng_pkg::SIZE_W-1:0] i_y_size,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  gmng_pkg::t_req              i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output gmng_pkg::t_move             o_out,
    output gmng_pkg::t_mem_req          o_mem,
    input  logic                        i_mem_rd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    typedef struct packed {
        logic [gmng_pkg::DIR_W-1:0]   dir;
        logic [gmng_pkg::COORD_W-1:0] nx;
        logic [gmng_pkg::COORD_W-1:0] ny;
        logic                         inb;
    } t_stage;

    t_state                        r_state,  n_state;
    logic [gmng_pkg::COORD_W-1:0]  r_tgt_x,  n_tgt_x;
    logic [gmng_pkg::COORD_W-1:0]  r_tgt_y,  n_tgt_y;
    logic [gmng_pkg::COORD_W-1:0]  r_src_x,  n_src_x;
    logic [gmng_pkg::COORD_W-1:0]  r_src_y,  n_src_y;
    logic                          r_cov,    n_cov;
    logic                          r_carry,  n_carry;
    logic                          r_planar, n_planar;
    logic [gmng_pkg::DCNT_W-1:0]   r_dir,    n_dir;
    t_stage                        r_s1,     n_s1;
    logic                          r_s1_vld, n_s1_vld;
    logic [gmng_pkg::NUM_AXIS-1:0] r_free,   n_free;
    gmng_pkg::t_move               r_pend,   n_pend;
    logic                          r_pend_vld, n_pend_vld;
    gmng_pkg::t_move               r_out,    n_out;
    logic                          r_out_vld, n_out_vld;

    logic [gmng_pkg::SIZE_W-1:0]   su_nx;
    logic [gmng_pkg::SIZE_W-1:0]   su_ny;
    logic                          su_inb;
    logic                          in_fire;
    logic [gmng_pkg::DCNT_W-1:0]   dir_end;
    logic                          more_dirs;
    logic                          axis;
    logic [1:0]                    corner_a;
    logic [1:0]                    corner_b;
    logic                          legal;
    logic                          out_free;
    logic                          advance;
    logic                          issue;
    gmng_pkg::t_move               new_move;
    gmng_pkg::t_move               miss_move;
    gmng_pkg::t_move               final_move;

    gmng_step_unit u_step (
        .i_src_x  (r_src_x),
        .i_src_y  (r_src_y),
        .i_dir    (r_dir[gmng_pkg::DIR_W-1:0]),
        .i_x_size (i_x_size),
        .i_y_size (i_y_size),
        .o_nx     (su_nx),
        .o_ny     (su_ny),
        .o_inb    (su_inb)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign dir_end    = r_planar ? gmng_pkg::DCNT_W'(gmng_pkg::NUM_DIR)
                                 : gmng_pkg::DCNT_W'(gmng_pkg::NUM_AXIS);
    assign more_dirs  = (r_dir != dir_end);

    // diagonal corners are the x-axis and y-axis neighbors on the same side
    assign axis     = !r_s1.dir[2];
    assign corner_a = {1'b0, r_s1.dir[1]};
    assign corner_b = {1'b1, r_s1.dir[0]};
    assign legal    = r_s1_vld && r_s1.inb &&
                      (r_cov || (!i_mem_rd &&
                                 (axis || (r_free[corner_a] && r_free[corner_b]))));
    assign out_free = !r_out_vld || i_out_ready;
    assign advance  = !(legal && r_pend_vld && !out_free);
    assign issue    = (r_state == ST_RUN) && more_dirs && advance;

    always_comb begin
        new_move              = '0;
        new_move.from_x       = r_src_x;
        new_move.from_y       = r_src_y;
        new_move.to_x         = r_s1.nx;
        new_move.to_y         = r_s1.ny;
        new_move.move_cost    = axis ? gmng_pkg::COST_W'(gmng_pkg::AXIS_COST)
                                     : gmng_pkg::COST_W'(gmng_pkg::DIAG_COST);
        new_move.target_moved = r_carry;
        new_move.found        = 1'b1;
        miss_move             = '0;
        miss_move.from_x      = r_src_x;
        miss_move.from_y      = r_src_y;
        miss_move.last        = 1'b1;
        final_move            = r_pend;
        final_move.last       = 1'b1;
    end

    always_comb begin
        o_mem       = '0;
        o_mem.we    = in_fire && (r_state == ST_IDLE) &&
                      (i_in.req_type == gmng_pkg::REQ_WRITE) &&
                      (int'(i_in.cell_x) < gmng_pkg::MAX_DIM) &&
                      (int'(i_in.cell_y) < gmng_pkg::MAX_DIM);
        o_mem.waddr = gmng_pkg::occ_addr({1'b0, i_in.cell_x}, {1'b0, i_in.cell_y});
        o_mem.wdata = i_in.occupied;
        o_mem.re    = issue;
        o_mem.raddr = gmng_pkg::occ_addr(su_nx, su_ny);
    end

    always_comb begin
        n_state    = r_state;
        n_tgt_x    = r_tgt_x;
        n_tgt_y    = r_tgt_y;
        n_src_x    = r_src_x;
        n_src_y    = r_src_y;
        n_cov      = r_cov;
        n_carry    = r_carry;
        n_planar   = r_planar;
        n_dir      = r_dir;
        n_s1       = r_s1;
        n_s1_vld   = r_s1_vld;
        n_free     = r_free;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = r_out_vld;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.req_type)
                        gmng_pkg::REQ_TARGET: begin
                            n_tgt_x = i_in.cell_x;
                            n_tgt_y = i_in.cell_y;
                        end
                        gmng_pkg::REQ_EXPAND: begin
                            n_src_x  = i_in.cell_x;
                            n_src_y  = i_in.cell_y;
                            n_cov    = 1'b0;
                            n_carry  = (i_in.cell_x == r_tgt_x) && (i_in.cell_y == r_tgt_y);
                            n_planar = i_in.planar;
                            n_dir    = '0;
                            n_state  = ST_RUN;
                        end
                        gmng_pkg::REQ_COVER: begin
                            n_src_x  = r_tgt_x;
                            n_src_y  = r_tgt_y;
                            n_cov    = 1'b1;
                            n_carry  = 1'b1;
                            n_planar = i_in.planar;
                            n_dir    = '0;
                            n_state  = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (advance) begin
                    if (more_dirs) begin
                        n_s1.dir = r_dir[gmng_pkg::DIR_W-1:0];
                        n_s1.nx  = su_nx[gmng_pkg::COORD_W-1:0];
                        n_s1.ny  = su_ny[gmng_pkg::COORD_W-1:0];
                        n_s1.inb = su_inb;
                        n_s1_vld = 1'b1;
                        n_dir    = r_dir + 1'b1;
                    end else begin
                        n_s1_vld = 1'b0;
                    end
                    if (r_s1_vld && axis) begin
                        n_free[r_s1.dir[1:0]] = r_s1.inb && !i_mem_rd;
                    end
                    if (legal) begin
                        n_pend     = new_move;
                        n_pend_vld = 1'b1;
                        if (r_pend_vld) begin
                            n_out     = r_pend;
                            n_out_vld = 1'b1;
                        end
                    end
                end
                if (!more_dirs && !r_s1_vld) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out      = r_pend_vld ? final_move : miss_move;
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tgt_x    <= '0;
            r_tgt_y    <= '0;
            r_dir      <= '0;
            r_s1_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tgt_x    <= n_tgt_x;
            r_tgt_y    <= n_tgt_y;
            r_dir      <= n_dir;
            r_s1_vld   <= n_s1_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_x  <= n_src_x;
        r_src_y  <= n_src_y;
        r_cov    <= n_cov;
        r_carry  <= n_carry;
        r_planar <= n_planar;
        r_s1     <= n_s1;
        r_free   <= n_free;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `GMNG_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_vld)
    `GMNG_ASSERT_IMP(a_stage_in_run, i_clk, i_rst_n, r_s1_vld, r_state == ST_RUN)
    `GMNG_ASSERT_NXT(a_flush_last, i_clk, i_rst_n, (r_state == ST_FLUSH) && out_free, r_out_vld && r_out.last)
    `GMNG_ASSERT_IMP(a_miss_shape, i_clk, i_rst_n, r_out_vld && !r_out.found, r_out.last && (r_out.move_cost == '0))
    `GMNG_ASSERT_IMP(a_dir_range, i_clk, i_rst_n, 1'b1, r_dir <= gmng_pkg::DCNT_W'(gmng_pkg::NUM_DIR))

endmodule

/* rtl/core/grid_move_neighbor_generator_top.sv */
// Top level of the grid move neighbor generator: stream ports, size registers,
// occupancy store and sequencer. Depends on gmng_pkg, gmng_occ_mem, gmng_seq.
//
//   channel  | dir | handshake              | payload
//   s_axis   | in  | s_axis_tvalid/tready   | tdata cell, tuser req_type
//   m_axis   | out | m_axis_tvalid/tready   | tdata move, tuser found, tlast
//   cfg      | in  | i_cfg_we               | i_cfg_index, i_cfg_wdata
//
// An expansion visits N = 4 or 8 directions, one direction per cycle unless a
// stalled output holds it, through the shared step unit and the single
// occupancy read port.
// Reset clears the grid (per-cell valid flops), the target and the sizes to 16.
// A stalled output holds the sequencer whenever a further move or the closing
// transfer of an expansion waits behind the output register.
module grid_move_neighbor_generator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gmng_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gmng_pkg::SIZE_W-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // cell_x, cell_y, occupied, planar
    input  logic [1:0]                      s_axis_tuser,  // req_type
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [31:0]                     m_axis_tdata,  // from_x, from_y, to_x, to_y,
                                                           // move_cost, target_moved
    output logic [0:0]                      m_axis_tuser,  // found
    output logic                            m_axis_tlast
);

    logic [gmng_pkg::SIZE_W-1:0] r_grid_x_size;
    logic [gmng_pkg::SIZE_W-1:0] r_grid_y_size;
    logic [gmng_pkg::SIZE_W-1:0] x_used;
    logic [gmng_pkg::SIZE_W-1:0] y_used;
    gmng_pkg::t_req              in_req;
    gmng_pkg::t_move             out_move;
    gmng_pkg::t_mem_req          mem_req;
    logic                        mem_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x_size <= gmng_pkg::SIZE_W'(16);
            r_grid_y_size <= gmng_pkg::SIZE_W'(16);
        end else if (i_cfg_we) begin
            if (i_cfg_index == gmng_pkg::CFG_GRID_X) begin
                r_grid_x_size <= i_cfg_wdata;
            end
            if (i_cfg_index == gmng_pkg::CFG_GRID_Y) begin
                r_grid_y_size <= i_cfg_wdata;
            end
        end
    end

    assign x_used = (r_grid_x_size > gmng_pkg::SIZE_W'(gmng_pkg::SIZE_LIMIT))
                  ? gmng_pkg::SIZE_W'(gmng_pkg::SIZE_LIMIT) : r_grid_x_size;
    assign y_used = (r_grid_y_size > gmng_pkg::SIZE_W'(gmng_pkg::SIZE_LIMIT))
                  ? gmng_pkg::SIZE_W'(gmng_pkg::SIZE_LIMIT) : r_grid_y_size;

    always_comb begin
        in_req.req_type = gmng_pkg::t_req_type'(s_axis_tuser);
        in_req.cell_x   = s_axis_tdata[3:0];
        in_req.cell_y   = s_axis_tdata[7:4];
        in_req.occupied = s_axis_tdata[8];
        in_req.planar   = s_axis_tdata[9];
    end

    gmng_occ_mem u_occ (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rd)
    );

    gmng_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_x_size    (x_used),
        .i_y_size    (y_used),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in        (in_req),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (out_move),
        .o_mem       (mem_req),
        .i_mem_rd    (mem_rd)
    );

    assign m_axis_tdata = {7'b0, out_move.target_moved, out_move.move_cost,
                           out_move.to_y, out_move.to_x, out_move.from_y, out_move.from_x};
    assign m_axis_tuser = out_move.found;
    assign m_axis_tlast = out_move.last;

endmodule
